[src/whps_pkg.sv]
// Shared types and constants for the weighted hash path select unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package whps_pkg;

  localparam int HASH_W      = 64;
  localparam int CNT_W       = 64;
  localparam int BYTES_W     = 16;
  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = 18;
  localparam int COUNT_W     = 3;
  localparam int SEL_W       = 3;
  localparam int ACT_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int NUM_WEIGHTS = 4;

  localparam int REG_IDX_W   = 3;
  localparam int REG_DATA_W  = 16;

  // Register map
  localparam logic [REG_IDX_W-1:0] REG_ACTION_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_ZERO  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_ONE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_TWO   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_THREE = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_CHOSEN = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  // Modulo unit: hash bits retired per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int DIV_STEPS     = HASH_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load_in;   // capture the input word, start the remainder
    logic div_step;  // retire BITS_PER_STEP hash bits
    logic pick;      // resolve status and action
    logic load_out;  // update counters, fill the output register
  } cmd_t;

  typedef struct packed {
    logic need_div;  // word on the input port needs the hash modulo
  } sts_t;

endpackage

[src/weighted_hash_path_select_unit.sv]
// Weighted hash path select unit: top level joining controller and datapath.
// In hash mode with two or more weighted actions a word runs through DIVIDE
// (the modulo unit retires 4 hash bits per step), then PICK and UPDATE; otherwise
// it goes straight to PICK and UPDATE. No new word is taken before the last leaves UPDATE.
// Reset (synchronous, active high) clears the configuration registers, weights and counters.
`timescale 1ns / 1ps

module weighted_hash_path_select_unit #(
  parameter int MAX_ACTIONS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [whps_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [whps_pkg::REG_DATA_W-1:0] wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [whps_pkg::HASH_W-1:0]     flow_hash,
  input  logic [whps_pkg::SEL_W-1:0]      action_select,
  input  logic [whps_pkg::BYTES_W-1:0]    packet_bytes,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [whps_pkg::STATUS_W-1:0]   status,
  output logic [whps_pkg::ACT_W-1:0]      chosen_action,
  output logic [whps_pkg::CNT_W-1:0]      packet_total,
  output logic [whps_pkg::CNT_W-1:0]      byte_total,
  output logic                            byte_overflow
);

  whps_pkg::cmd_t cmd;
  whps_pkg::sts_t sts;

  whps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  whps_dp #(
    .MAX_ACTIONS (MAX_ACTIONS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .func          (func),
    .flow_hash     (flow_hash),
    .action_select (action_select),
    .packet_bytes  (packet_bytes),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .chosen_action (chosen_action),
    .packet_total  (packet_total),
    .byte_total    (byte_total),
    .byte_overflow (byte_overflow)
  );

  // one word in flight: no accept right after an accept
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a word without a chosen action carries zero fields
  a_unchosen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != whps_pkg::ST_CHOSEN |->
      chosen_action == '0 && packet_total == '0 && byte_total == '0 && !byte_overflow)
    else $error("nonzero fields on a word without a chosen action");

  // saturation leaves the byte total at its maximum
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_overflow |-> (&byte_total))
    else $error("byte overflow flagged without a saturated total");

endmodule

[src/whps_ctrl.sv]
// Controller state machine for the weighted hash path select unit.
// Depends on whps_pkg for the command and status structs.
`timescale 1ns / 1ps

module whps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  whps_pkg::sts_t sts,
  output whps_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    PICK,
    UPDATE
  } state_t;

  state_t                           state;
  logic [whps_pkg::STEP_CNT_W-1:0]  step_cnt;
  logic                             out_free;

  assign in_ready     = (state == IDLE);
  assign out_free     = !out_valid || out_ready;
  assign cmd.load_in  = (state == IDLE) && in_valid;
  assign cmd.div_step = (state == DIVIDE);
  assign cmd.pick     = (state == PICK);
  assign cmd.load_out = (state == UPDATE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          step_cnt <= '0;
          if (in_valid) begin
            state <= sts.need_div ? DIVIDE : PICK;
          end
        end
        DIVIDE: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == whps_pkg::STEP_CNT_W'(whps_pkg::DIV_STEPS - 1)) begin
            state <= PICK;
          end
        end
        PICK: begin
          state <= UPDATE;
        end
        UPDATE: begin
          // hold until the output register can take the word
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[src/whps_dp.sv]
// Datapath of the weighted hash path select unit: configuration registers,
// hash modulo unit, action pick, traffic counters and output register.
// Depends on whps_pkg for widths, codes and the command and status structs.
`timescale 1ns / 1ps

module whps_dp #(
  parameter int MAX_ACTIONS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [whps_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [whps_pkg::REG_DATA_W-1:0]    wr_data,
  input  logic                               func,
  input  logic [whps_pkg::HASH_W-1:0]        flow_hash,
  input  logic [whps_pkg::SEL_W-1:0]         action_select,
  input  logic [whps_pkg::BYTES_W-1:0]       packet_bytes,
  input  whps_pkg::cmd_t                     cmd,
  output whps_pkg::sts_t                     sts,
  output logic [whps_pkg::STATUS_W-1:0]      status,
  output logic [whps_pkg::ACT_W-1:0]         chosen_action,
  output logic [whps_pkg::CNT_W-1:0]         packet_total,
  output logic [whps_pkg::CNT_W-1:0]         byte_total,
  output logic                               byte_overflow
);

  localparam int IW = $clog2(MAX_ACTIONS);

  // configuration
  logic [whps_pkg::COUNT_W-1:0]  action_count;
  logic [whps_pkg::WEIGHT_W-1:0] weights [whps_pkg::NUM_WEIGHTS];

  // captured word and modulo state
  logic                          func_q;
  logic [whps_pkg::SEL_W-1:0]    sel_q;
  logic [whps_pkg::BYTES_W-1:0]  bytes_q;
  logic [whps_pkg::HASH_W-1:0]   dividend;
  logic [whps_pkg::SUM_W-1:0]    rem;
  logic [whps_pkg::HASH_W-1:0]   dividend_next;
  logic [whps_pkg::SUM_W-1:0]    rem_next;

  // pick result
  logic [whps_pkg::STATUS_W-1:0] pick_status;
  logic [whps_pkg::ACT_W-1:0]    pick_action;

  // counters
  logic [whps_pkg::CNT_W-1:0]    packet_counts [MAX_ACTIONS];
  logic [whps_pkg::CNT_W-1:0]    byte_counts   [MAX_ACTIONS];

  logic [whps_pkg::COUNT_W-1:0]  act_n;
  logic [whps_pkg::SUM_W-1:0]    cum [whps_pkg::NUM_WEIGHTS];
  logic [whps_pkg::SUM_W-1:0]    weight_sum;
  logic [whps_pkg::STATUS_W-1:0] status_comb;
  logic [whps_pkg::ACT_W-1:0]    action_comb;
  logic [IW-1:0]                 idx;
  logic [whps_pkg::CNT_W-1:0]    pkt_new;
  logic [whps_pkg::CNT_W:0]      byte_sum;
  logic [whps_pkg::CNT_W-1:0]    byte_new;

  // active actions and cumulative weights of the active ones
  always_comb begin
    logic [whps_pkg::SUM_W-1:0] acc;
    acc = '0;
    if (action_count > whps_pkg::COUNT_W'(MAX_ACTIONS)) begin
      act_n = whps_pkg::COUNT_W'(MAX_ACTIONS);
    end else begin
      act_n = action_count;
    end
    for (int k = 0; k < whps_pkg::NUM_WEIGHTS; k++) begin
      if (whps_pkg::COUNT_W'(k) < act_n) begin
        acc = acc + whps_pkg::SUM_W'(weights[k]);
      end
      cum[k] = acc;
    end
    weight_sum = acc;
  end

  assign sts.need_div = !func && (act_n > whps_pkg::COUNT_W'(1)) && (weight_sum != '0);

  // restoring modulo, BITS_PER_STEP dividend bits per cycle
  always_comb begin
    logic [whps_pkg::SUM_W:0]    t;
    logic [whps_pkg::SUM_W-1:0]  r;
    logic [whps_pkg::HASH_W-1:0] d;
    r = rem;
    d = dividend;
    for (int i = 0; i < whps_pkg::BITS_PER_STEP; i++) begin
      t = {r, d[whps_pkg::HASH_W-1]};
      d = {d[whps_pkg::HASH_W-2:0], 1'b0};
      if (t >= {1'b0, weight_sum}) begin
        t = t - {1'b0, weight_sum};
      end
      r = t[whps_pkg::SUM_W-1:0];
    end
    rem_next      = r;
    dividend_next = d;
  end

  // status and action from the captured word
  always_comb begin
    status_comb = whps_pkg::ST_CHOSEN;
    action_comb = '0;
    if (!func_q) begin
      if (act_n == whps_pkg::COUNT_W'(1)) begin
        action_comb = '0;
      end else if (weight_sum == '0) begin
        status_comb = whps_pkg::ST_NONE;
      end else begin
        action_comb = whps_pkg::ACT_W'(act_n - 1'b1);
        // lowest action whose cumulative weight passes the remainder wins
        for (int k = whps_pkg::NUM_WEIGHTS - 1; k >= 0; k--) begin
          if (whps_pkg::COUNT_W'(k) < act_n && rem < cum[k]) begin
            action_comb = whps_pkg::ACT_W'(k);
          end
        end
      end
    end else begin
      if (sel_q < act_n) begin
        action_comb = sel_q[whps_pkg::ACT_W-1:0];
      end else begin
        status_comb = whps_pkg::ST_RANGE;
      end
    end
  end

  assign idx      = pick_action[IW-1:0];
  assign pkt_new  = packet_counts[idx] + 1'b1;
  assign byte_sum = {1'b0, byte_counts[idx]} + (whps_pkg::CNT_W + 1)'(bytes_q);
  assign byte_new = byte_sum[whps_pkg::CNT_W] ? '1 : byte_sum[whps_pkg::CNT_W-1:0];

  // configuration registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      action_count <= '0;
      for (int k = 0; k < whps_pkg::NUM_WEIGHTS; k++) begin
        weights[k] <= '0;
      end
      for (int k = 0; k < MAX_ACTIONS; k++) begin
        packet_counts[k] <= '0;
        byte_counts[k]   <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          whps_pkg::REG_ACTION_COUNT: action_count <= wr_data[whps_pkg::COUNT_W-1:0];
          whps_pkg::REG_WEIGHT_ZERO:  weights[0]   <= wr_data;
          whps_pkg::REG_WEIGHT_ONE:   weights[1]   <= wr_data;
          whps_pkg::REG_WEIGHT_TWO:   weights[2]   <= wr_data;
          whps_pkg::REG_WEIGHT_THREE: weights[3]   <= wr_data;
          default: begin
          end
        endcase
      end
      if (cmd.load_out && pick_status == whps_pkg::ST_CHOSEN) begin
        packet_counts[idx] <= pkt_new;
        byte_counts[idx]   <= byte_new;
      end
    end
  end

  // captured word, modulo, pick and output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_q   <= func;
      sel_q    <= action_select;
      bytes_q  <= packet_bytes;
      dividend <= flow_hash;
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend_next;
      rem      <= rem_next;
    end
    if (cmd.pick) begin
      pick_status <= status_comb;
      pick_action <= action_comb;
    end
    if (cmd.load_out) begin
      status <= pick_status;
      if (pick_status == whps_pkg::ST_CHOSEN) begin
        chosen_action <= pick_action;
        packet_total  <= pkt_new;
        byte_total    <= byte_new;
        byte_overflow <= byte_sum[whps_pkg::CNT_W];
      end else begin
        chosen_action <= '0;
        packet_total  <= '0;
        byte_total    <= '0;
        byte_overflow <= 1'b0;
      end
    end
  end

endmodule
